// ===== design/tstf_pkg.sv =====
// Shared constants, types and command/status structs of the time-tagged store forwarding table.
package tstf_pkg;

  // Table geometry.
  localparam int ROWS      = 32;
  localparam int COLUMNS   = 8;
  localparam int PATHS     = 4;
  localparam int ADDR_BITS = 32;
  localparam int DATA_BITS = 32;

  // Fixed field widths on the ports.
  localparam int IN_ROW_W   = 5;
  localparam int IN_COL_W   = 3;
  localparam int IN_PATH_W  = 2;
  localparam int IN_ADDR_W  = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int IN_FIELD_W = IN_ROW_W + IN_COL_W + IN_PATH_W + IN_ADDR_W + IN_DATA_W;
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

  // Index widths of the slot memory; the memory is addressed by {path, column, row}.
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PATH_W  = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int SLOT_W  = ROW_W + COL_W + PATH_W;
  localparam int SLOT_DEPTH = 2 ** SLOT_W;

  // Stored widths: only the low bits that take part in the compare are kept.
  localparam int ADDR_W = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
  localparam int DATA_W = (DATA_BITS < IN_DATA_W) ? DATA_BITS : IN_DATA_W;
  localparam int WORD_W = 1 + ADDR_W + DATA_W;

  // Operation carried in tuser.
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_LOAD  = 1'b1
  } tstf_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tstf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic store_en;
    logic load_start;
    logic scan_en;
    logic res_capture;
    logic out_load;
  } tstf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic found;
    logic miss_end;
    logic out_free;
  } tstf_status_t;

endpackage

// ===== design/tstf_ctrl.sv =====
// Controller state machine of the store forwarding table: clear pass, accept, scan and hand-off.
module tstf_ctrl
  import tstf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  tstf_op_e     op_i,
  input  tstf_status_t st_i,
  output tstf_cmd_t    cmd_o
);

  tstf_state_e state_q, state_d;
  logic        accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && op_i == OP_LOAD) begin
          state_d = st_i.in_range ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (st_i.found || st_i.miss_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (op_i == OP_STORE) begin
            cmd_o.store_en = st_i.in_range;
          end else if (st_i.in_range) begin
            cmd_o.load_start = 1'b1;
          end else begin
            // A load outside the table finds nothing.
            cmd_o.res_capture = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (st_i.found || st_i.miss_end) begin
          cmd_o.res_capture = 1'b1;
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      ST_DONE: begin
        cmd_o.out_load = st_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // A probe result only ever arrives during a scan.
  a_probe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_i.found || st_i.miss_end) |-> state_q == ST_SCAN)
    else $error("probe result outside a scan");

  // A captured result is always handed to the output stage next.
  a_capture_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_capture |=> state_q == ST_DONE)
    else $error("captured result not followed by hand-off");

  // No item is taken until the clear pass has finished.
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd_o.store_en && !cmd_o.load_start)
    else $error("item taken during the clear pass");

endmodule

// ===== design/tstf_dp.sv =====
// Datapath of the store forwarding table: slot memory, scan cursor, compare and output register.
module tstf_dp
  import tstf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tstf_cmd_t             cmd_i,
  output tstf_status_t          st_o,
  input  logic [IN_ROW_W-1:0]   row_slot_i,
  input  logic [IN_COL_W-1:0]   column_slot_i,
  input  logic [IN_PATH_W-1:0]  path_num_i,
  input  logic [IN_ADDR_W-1:0]  mem_addr_i,
  input  logic [IN_DATA_W-1:0]  store_data_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic                  m_hit_o,
  output logic [OUT_DATA_W-1:0] m_load_data_o
);

  // Slot memory: {valid, address, value} per slot.
  logic [WORD_W-1:0] mem_q [SLOT_DEPTH];
  logic [WORD_W-1:0] rd_word_q;

  logic [SLOT_W-1:0] clr_cnt_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [COL_W-1:0]  cur_col_q;
  logic [PATH_W-1:0] cur_path_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic              issued_all_q;
  logic              rd_vld_q;
  logic              rd_last_q;
  logic              res_hit_q;
  logic [DATA_W-1:0] res_data_q;
  logic              out_valid_q;
  logic              out_hit_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic              in_range;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [PATH_W-1:0] in_path;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_idx;
  logic [WORD_W-1:0] wr_word;
  logic              scan_issue;
  logic              cur_origin;
  logic [SLOT_W-1:0] cur_idx;
  logic              match;
  logic              found;
  logic              out_free;

  // Input range check and index fields.
  assign in_range = (32'(row_slot_i) < 32'(ROWS)) && (32'(column_slot_i) < 32'(COLUMNS)) &&
                    (32'(path_num_i) < 32'(PATHS));
  assign in_row   = ROW_W'(row_slot_i);
  assign in_col   = COL_W'(column_slot_i);
  assign in_path  = PATH_W'(path_num_i);

  // Write port: clear pass or store.
  assign wr_en   = cmd_i.clr_en || cmd_i.store_en;
  assign wr_idx  = cmd_i.clr_en ? clr_cnt_q : {in_path, in_col, in_row};
  assign wr_word = cmd_i.clr_en ? '0 :
                   {1'b1, mem_addr_i[ADDR_W-1:0], store_data_i[DATA_W-1:0]};

  // Read port: one probe per scan cycle, newest slot first.
  assign cur_idx    = {cur_path_q, cur_col_q, cur_row_q};
  assign cur_origin = (cur_row_q == '0) && (cur_col_q == '0);
  assign scan_issue = cmd_i.scan_en && !issued_all_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_word;
    if (scan_issue) rd_word_q <= mem_q[cur_idx];
  end

  // Compare of the registered read word with the load address.
  assign match = rd_word_q[WORD_W-1] && (rd_word_q[DATA_W +: ADDR_W] == req_addr_q);
  assign found = rd_vld_q && match;
  assign out_free = !out_valid_q || m_tready_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
      if (cmd_i.load_start) begin
        issued_all_q <= 1'b0;
      end else if (scan_issue && cur_origin) begin
        issued_all_q <= 1'b1;
      end
      rd_vld_q <= scan_issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan cursor and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      cur_row_q  <= in_row;
      cur_col_q  <= in_col;
      cur_path_q <= in_path;
      req_addr_q <= mem_addr_i[ADDR_W-1:0];
    end else if (scan_issue) begin
      // Step down the rows, then into the previous column from its last row.
      if (cur_row_q != '0) begin
        cur_row_q <= cur_row_q - ROW_W'(1);
      end else if (cur_col_q != '0) begin
        cur_col_q <= cur_col_q - COL_W'(1);
        cur_row_q <= ROW_W'(ROWS - 1);
      end
    end
    if (scan_issue) rd_last_q <= cur_origin;
    if (cmd_i.res_capture) begin
      res_hit_q  <= found;
      res_data_q <= found ? rd_word_q[DATA_W-1:0] : '0;
    end
    if (cmd_i.out_load) begin
      out_hit_q  <= res_hit_q;
      out_data_q <= OUT_DATA_W'(res_data_q);
    end
  end

  assign st_o.clr_last = (clr_cnt_q == SLOT_W'(SLOT_DEPTH - 1));
  assign st_o.in_range = in_range;
  assign st_o.found    = found;
  assign st_o.miss_end = rd_vld_q && rd_last_q && !match;
  assign st_o.out_free = out_free;

  assign m_tvalid_o    = out_valid_q;
  assign m_hit_o       = out_hit_q;
  assign m_load_data_o = out_data_q;

  // The output stage is only loaded when it can take an item.
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output register overwritten");

  // The clear pass and a store never share the write port.
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_en && cmd_i.store_en))
    else $error("two writes in one cycle");

  // No probe is issued past the oldest slot of the scan.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && rd_last_q) |=> !rd_vld_q)
    else $error("probe issued after the last slot");

endmodule

// ===== design/time_tagged_store_forward_table.sv =====
// Top level of the time-tagged store forwarding table.
//
// Items enter on the s_axis channel: tuser carries the operation (store or load),
// tdata the row, column and path tags, the address and the store value. A store
// writes its slot in the cycle it is accepted and gives no result. A load searches
// the slots of its path, first its own column from its row down to row 0, then each
// earlier column from the last row down, and gives one result on m_axis: tuser is
// the hit flag, tdata the value of the newest matching store, zero on a miss.
// Items are taken one at a time. A load presents its result once its scan matches or
// passes the oldest slot; the slot memory is read once per cycle while it scans,
// so a scan probes at most ROWS * COLUMNS slots (256 here). The next item is taken in
// the cycle after the result enters the output register. A load outside the table
// answers a miss without a scan; after a store the next item can be taken next cycle.
// After reset the block runs a clear pass over all 1024 slots, one per cycle, with
// s_axis_tready low. A finished result waits in the output register while
// m_axis_tready is low; the next item is still accepted, and the following load's
// result is held until the output register is free.
module time_tagged_store_forward_table
  import tstf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata from bit 0: row_slot, column_slot, path_num, mem_addr, store_data, zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: cmd
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: load_data
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: hit
  output logic                  m_axis_tuser
);

  localparam int COL_LSB  = IN_ROW_W;
  localparam int PATH_LSB = COL_LSB + IN_COL_W;
  localparam int ADDR_LSB = PATH_LSB + IN_PATH_W;
  localparam int DATA_LSB = ADDR_LSB + IN_ADDR_W;

  tstf_cmd_t    cmd;
  tstf_status_t st;
  tstf_op_e     op;

  assign op = tstf_op_e'(s_axis_tuser);

  tstf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_i          (op),
    .st_i          (st),
    .cmd_o         (cmd)
  );

  tstf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .row_slot_i    (s_axis_tdata[COL_LSB-1:0]),
    .column_slot_i (s_axis_tdata[PATH_LSB-1:COL_LSB]),
    .path_num_i    (s_axis_tdata[ADDR_LSB-1:PATH_LSB]),
    .mem_addr_i    (s_axis_tdata[DATA_LSB-1:ADDR_LSB]),
    .store_data_i  (s_axis_tdata[DATA_LSB+IN_DATA_W-1:DATA_LSB]),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .m_hit_o       (m_axis_tuser),
    .m_load_data_o (m_axis_tdata)
  );

endmodule

// ===== test/time_tagged_store_forward_table_checker.sv =====
// Checker for the store forwarding table: predicts every load answer and compares results.
`timescale 1ns / 100ps

module time_tagged_store_forward_table_checker
  import tstf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata from bit 0: row_slot, column_slot, path_num, mem_addr, store_data, zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: cmd
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: load_data
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: hit
  input  logic                  m_axis_tuser,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_loads_o
);

  // One input item as it lies in tdata; the first member sits in the top bits.
  typedef struct packed {
    logic [IN_TDATA_W-IN_FIELD_W-1:0] fill;
    logic [IN_DATA_W-1:0]             data;
    logic [IN_ADDR_W-1:0]             addr;
    logic [IN_PATH_W-1:0]             path;
    logic [IN_COL_W-1:0]              col;
    logic [IN_ROW_W-1:0]              row;
  } access_t;

  // Answer of one load as it should leave on the result channel.
  typedef struct packed {
    logic                  hit;
    logic [OUT_DATA_W-1:0] data;
  } load_answer_t;

  // Shadow copy of the slot table, indexed by path, column and row.
  logic [ADDR_W-1:0] slot_tag  [PATHS][COLUMNS][ROWS];
  logic [DATA_W-1:0] slot_word [PATHS][COLUMNS][ROWS];
  logic              slot_live [PATHS][COLUMNS][ROWS];

  load_answer_t answers_q [$];
  load_answer_t want;
  access_t      acc;

  assign acc = access_t'(s_axis_tdata);

  // Search the load's path: its own column from its row down, then older columns top down.
  function automatic load_answer_t forward_search(input access_t a);
    load_answer_t ans;
    int r;
    int c;
    ans = '0;
    if (a.row >= ROWS || a.col >= COLUMNS || a.path >= PATHS) begin
      return ans;
    end
    for (r = int'(a.row); r >= 0; r--) begin
      if (slot_live[a.path][a.col][r] && slot_tag[a.path][a.col][r] == a.addr[ADDR_W-1:0]) begin
        ans.hit  = 1'b1;
        ans.data = OUT_DATA_W'(slot_word[a.path][a.col][r]);
        return ans;
      end
    end
    for (c = int'(a.col) - 1; c >= 0; c--) begin
      for (r = ROWS - 1; r >= 0; r--) begin
        if (slot_live[a.path][c][r] && slot_tag[a.path][c][r] == a.addr[ADDR_W-1:0]) begin
          ans.hit  = 1'b1;
          ans.data = OUT_DATA_W'(slot_word[a.path][c][r]);
          return ans;
        end
      end
    end
    return ans;
  endfunction

  // Results are retired before the input item of the same edge is applied to the table.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_live[p, c, r]) slot_live[p][c][r] = 1'b0;
      answers_q.delete();
      mismatch_count_o = 0;
      pending_loads_o  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("unexpected result: hit=%0b data=%h", m_axis_tuser, m_axis_tdata);
          end
          mismatch_count_o++;
        end else begin
          want = answers_q.pop_front();
          if (m_axis_tuser !== want.hit || m_axis_tdata !== want.data) begin
            if (mismatch_count_o < 10) begin
              $display("load result mismatch: expected hit=%0b data=%h, got hit=%0b data=%h",
                       want.hit, want.data, m_axis_tuser, m_axis_tdata);
            end
            mismatch_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD) begin
          answers_q.push_back(forward_search(acc));
        end else if (acc.row < ROWS && acc.col < COLUMNS && acc.path < PATHS) begin
          slot_tag[acc.path][acc.col][acc.row]  = acc.addr[ADDR_W-1:0];
          slot_word[acc.path][acc.col][acc.row] = acc.data[DATA_W-1:0];
          slot_live[acc.path][acc.col][acc.row] = 1'b1;
        end
      end
      pending_loads_o = answers_q.size();
    end
  end

endmodule

// ===== test/time_tagged_store_forward_table_tb.sv =====
// Testbench top of the store forwarding table: clock, reset, stores and loads, verdict.
`timescale 1ns / 100ps

module time_tagged_store_forward_table_tb
  import tstf_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS    = 1780;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned TAIL_CYCLES     = 300;
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned ADDR_POOL       = 16;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_STORE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  int unsigned mismatches;
  int unsigned pending_loads;
  int unsigned quiet_cycles = 0;
  logic        sender_calm  = 1'b0;

  logic [IN_ADDR_W-1:0] addr_pool [ADDR_POOL];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  time_tagged_store_forward_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  time_tagged_store_forward_table_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatches),
    .pending_loads_o  (pending_loads)
  );

  // Offer one item, with random idle cycles in front, and wait until it is taken.
  task automatic send_item(input tstf_op_e op, input int unsigned row,
                           input int unsigned col, input int unsigned path,
                           input logic [IN_ADDR_W-1:0] addr, input logic [IN_DATA_W-1:0] data);
    while (!sender_calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELD_W){1'b0}}, data, addr, IN_PATH_W'(path),
                      IN_COL_W'(col), IN_ROW_W'(row)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering items until every load has answered.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_loads != 0);
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure, a calm stretch and two long hold-offs.
  initial begin : result_sink
    int unsigned taken;
    int unsigned n;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        taken++;
        if (taken == 100 || taken == 700) begin
          m_axis_tready <= 1'b0;
          for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk_i);
        end
      end
      m_axis_tready <= (taken >= 300 && taken < 500) || $urandom_range(99) >= 14;
    end
  end

  // Watchdog: ends the run when neither channel moves an item for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned k;
    tstf_op_e    op;
    logic [IN_ADDR_W-1:0] addr;

    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (k = 2; k < ADDR_POOL; k++) addr_pool[k] = $urandom();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A load on the empty table misses after the longest scan.
    send_item(OP_LOAD, 31, 7, 3, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_STORE, 0, 0, 0, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_STORE, 31, 7, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // The load's own slot takes part in the search.
    send_item(OP_LOAD, 31, 7, 3, 32'hFFFF_FFFF, 32'h0000_0000);
    // A match in the oldest slot of the path, found at the very end of the scan.
    send_item(OP_LOAD, 31, 7, 0, 32'h0000_0000, 32'h1234_5678);
    // Other paths never see the stores of path 0.
    send_item(OP_LOAD, 31, 7, 1, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_STORE, 5, 3, 2, 32'hA5A5_5A5A, 32'h1111_1111);
    send_item(OP_STORE, 10, 3, 2, 32'hA5A5_5A5A, 32'h2222_2222);
    // Younger rows of the same column are skipped; the newest older one wins.
    send_item(OP_LOAD, 7, 3, 2, 32'hA5A5_5A5A, 32'h0);
    send_item(OP_LOAD, 12, 3, 2, 32'hA5A5_5A5A, 32'h0);
    // A later column scans older columns from the last row down.
    send_item(OP_LOAD, 0, 4, 2, 32'hA5A5_5A5A, 32'h0);
    send_item(OP_LOAD, 4, 3, 2, 32'hA5A5_5A5A, 32'h0);
    // Overwriting a slot with another address hides its old match.
    send_item(OP_STORE, 10, 3, 2, 32'h5A5A_A5A5, 32'h3333_3333);
    send_item(OP_LOAD, 12, 3, 2, 32'hA5A5_5A5A, 32'h0);
    send_item(OP_LOAD, 12, 3, 2, 32'h5A5A_A5A5, 32'h0);
    // Shortest scan: row 0 of column 0.
    send_item(OP_LOAD, 0, 0, 1, 32'h0000_0000, 32'h0);
    send_item(OP_LOAD, 0, 0, 0, 32'h0000_0000, 32'h0);
    send_item(OP_STORE, 31, 0, 1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_LOAD, 0, 7, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();

    // Random part: addresses mostly from a small pool so that loads find stores.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 1200) begin
        drain_results();
      end
      sender_calm = (k >= 600 && k < 1000);
      op   = $urandom_range(1) ? OP_LOAD : OP_STORE;
      addr = ($urandom_range(99) < 80) ? addr_pool[$urandom_range(ADDR_POOL - 1)] : $urandom();
      send_item(op, $urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1),
                $urandom_range(PATHS - 1), addr, $urandom());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    if (mismatches == 0 && pending_loads == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== time_tagged_store_forward_table.f =====
design/tstf_pkg.sv
design/tstf_ctrl.sv
design/tstf_dp.sv
design/time_tagged_store_forward_table.sv
test/time_tagged_store_forward_table_checker.sv
test/time_tagged_store_forward_table_tb.sv
